>>> rtl/bracket_balance_checker_top_assert.svh
// Assertion macros for the bracket balance checker.
`ifndef BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BBC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket checker: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define BBC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket checker: next-cycle check failed");

`endif

>>> rtl/bbc_pkg.sv
// Types, constants and bracket decoders for the bracket balance checker.
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int POS_BITS_DEF    = 16;
    localparam int CH_W            = 8;
    localparam int WHERE_W         = 16;

    localparam logic [CH_W-1:0] CH_OPEN_PAREN   = 8'h28;
    localparam logic [CH_W-1:0] CH_CLOSE_PAREN  = 8'h29;
    localparam logic [CH_W-1:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [CH_W-1:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [CH_W-1:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [CH_W-1:0] CH_CLOSE_CURLY  = 8'h7D;

    typedef enum logic [2:0] {
        VERDICT_PENDING   = 3'd0,
        VERDICT_OK        = 3'd1,
        VERDICT_BAD_CLOSE = 3'd2,
        VERDICT_UNCLOSED  = 3'd3,
        VERDICT_OVERFLOW  = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } item_t;

    typedef struct packed {
        verdict_t             verdict;
        logic [WHERE_W-1:0]   where;
    } result_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } bracket_t;

    // Stack commands; clear wins over push and pop.
    typedef struct packed {
        logic  push;
        logic  pop;
        logic  clear;
        kind_t kind;
    } stack_ctl_t;

    typedef struct packed {
        logic  empty;
        logic  full;
        kind_t top_kind;
    } stack_stat_t;

    function automatic bracket_t decode_open(input logic [CH_W-1:0] c);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        unique case (c)
            CH_OPEN_PAREN:  b.kind = KIND_PAREN;
            CH_OPEN_SQUARE: b.kind = KIND_SQUARE;
            CH_OPEN_CURLY:  b.kind = KIND_CURLY;
            default:        b.hit  = 1'b0;
        endcase
        return b;
    endfunction

    function automatic bracket_t decode_close(input logic [CH_W-1:0] c);
        bracket_t b;
        b.hit  = 1'b1;
        b.kind = KIND_PAREN;
        unique case (c)
            CH_CLOSE_PAREN:  b.kind = KIND_PAREN;
            CH_CLOSE_SQUARE: b.kind = KIND_SQUARE;
            CH_CLOSE_CURLY:  b.kind = KIND_CURLY;
            default:         b.hit  = 1'b0;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/bbc_stack.sv
// Bracket stack: top entry in registers, deeper entries in a memory with registered read.
module bbc_stack #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    parameter int POS_BITS    = bbc_pkg::POS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bbc_pkg::stack_ctl_t                 ctl,
    input  logic [POS_BITS-1:0]                 push_where,
    output bbc_pkg::stack_stat_t                stat,
    output logic [POS_BITS-1:0]                 top_where,
    output logic [POS_BITS-1:0]                 below_where,
    output logic [$clog2(STACK_DEPTH+1)-1:0]    count
);
    import bbc_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int ENT_W = POS_BITS + 2;

    logic [ENT_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    logic [ENT_W-1:0] top_reg, top_next;
    logic [ENT_W-1:0] fwd_reg;
    logic             fwd_valid_reg;
    logic [ENT_W-1:0] rd_reg;
    logic [ENT_W-1:0] below;
    logic [CNT_W-1:0] rd_sum;
    logic [CNT_W-1:0] wr_sum;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;

    // Entry under the top: from the memory, or the old top right after a push.
    assign below = fwd_valid_reg ? fwd_reg : rd_reg;

    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = count_reg + 1'b1;
            top_next   = {ctl.kind, push_where};
        end
        else if (ctl.pop)
        begin
            count_next = count_reg - 1'b1;
            top_next   = below;
        end
    end

    // Prefetch the entry that will sit under the new top.
    assign rd_sum  = count_next - CNT_W'(2);
    assign rd_addr = rd_sum[AW-1:0];
    assign wr_sum  = count_reg - 1'b1;
    assign wr_addr = wr_sum[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.push && !ctl.clear && (count_reg != '0))
        begin
            mem[wr_addr] <= top_reg;
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (ctl.push)
        begin
            fwd_reg <= top_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            fwd_valid_reg <= ctl.push && !ctl.clear;
        end
    end

    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.top_kind = kind_t'(top_reg[ENT_W-1 -: 2]);
    assign top_where     = top_reg[POS_BITS-1:0];
    assign below_where   = below[POS_BITS-1:0];
    assign count         = count_reg;

endmodule

>>> rtl/bracket_balance_checker_top.sv
// Bracket balance checker: one character per beat in, one verdict per beat out.
// Each accepted character beat produces exactly one result beat, through the input register and
// then the result register, and a new character is taken every cycle while the
// result side keeps up. Opening brackets are pushed with their 1-based position; a closing
// bracket must match the kind on top or the first failing position is latched. Non-last beats
// return verdict pending; the beat flagged last returns success, bad closing (with position),
// unclosed opening (topmost position) or overflow, and then the checker starts a fresh string.
// The top of stack lives in registers and the entry beneath it is prefetched each cycle from a
// STACK_DEPTH-entry memory with one write and one registered read port, which sets the one
// character per cycle rate. Positions saturate at 2^POS_BITS-1; where carries their low 16 bits.
// Stack contents need no clearing after reset.
`include "bracket_balance_checker_top_assert.svh"

module bracket_balance_checker_top #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    parameter int POS_BITS    = bbc_pkg::POS_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  bbc_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_ready,
    output bbc_pkg::result_t  result
);
    import bbc_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic                in_valid_reg, in_valid_next;
    item_t               in_reg;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg, out_next;

    logic [POS_BITS-1:0] char_index_reg, char_index_next;
    logic                failed_reg, failed_next;
    logic [POS_BITS-1:0] fail_where_reg, fail_where_next;
    logic                overflowed_reg, overflowed_next;

    logic                advance;
    logic                process;
    logic                accept;
    logic [POS_BITS-1:0] pos;
    bracket_t            op;
    bracket_t            cl;
    logic                active;
    logic                push_req;
    logic                pop_req;
    logic                ovf_hit;
    logic                mismatch;
    logic                fail_after;
    logic                ovf_after;
    logic [POS_BITS-1:0] fail_where_after;
    logic [CNT_W-1:0]    count_after;
    logic [POS_BITS-1:0] where_after;

    stack_ctl_t          stk_ctl;
    stack_stat_t         stk_stat;
    logic [POS_BITS-1:0] stk_top_where;
    logic [POS_BITS-1:0] stk_below_where;
    logic [CNT_W-1:0]    stk_count;

    bbc_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .POS_BITS    (POS_BITS)
    ) u_stack (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (stk_ctl),
        .push_where  (pos),
        .stat        (stk_stat),
        .top_where   (stk_top_where),
        .below_where (stk_below_where),
        .count       (stk_count)
    );

    // Handshake: input and result registers decouple the two sides.
    assign advance    = !out_valid_reg || result_ready;
    assign process    = in_valid_reg && advance;
    assign item_ready = !in_valid_reg || advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (process)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (process)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Character processing for the beat in the input register.
    assign pos      = (&char_index_reg) ? char_index_reg : char_index_reg + 1'b1;
    assign op       = decode_open(in_reg.ch);
    assign cl       = decode_close(in_reg.ch);
    assign active   = !failed_reg && !overflowed_reg;
    assign push_req = active && op.hit && !stk_stat.full;
    assign ovf_hit  = active && op.hit && stk_stat.full;
    assign mismatch = active && cl.hit && (stk_stat.empty || (stk_stat.top_kind != cl.kind));
    assign pop_req  = active && cl.hit && !mismatch;

    assign fail_after       = failed_reg || mismatch;
    assign ovf_after        = overflowed_reg || ovf_hit;
    assign fail_where_after = mismatch ? pos : fail_where_reg;

    always_comb
    begin
        count_after = stk_count;
        where_after = stk_top_where;
        if (push_req)
        begin
            count_after = stk_count + 1'b1;
            where_after = pos;
        end
        else if (pop_req)
        begin
            count_after = stk_count - 1'b1;
            where_after = stk_below_where;
        end
    end

    assign stk_ctl.push  = process && push_req;
    assign stk_ctl.pop   = process && pop_req;
    assign stk_ctl.clear = process && in_reg.last;
    assign stk_ctl.kind  = op.kind;

    always_comb
    begin
        out_next.verdict = VERDICT_PENDING;
        out_next.where   = '0;
        if (in_reg.last)
        begin
            if (ovf_after)
            begin
                out_next.verdict = VERDICT_OVERFLOW;
            end
            else if (fail_after)
            begin
                out_next.verdict = VERDICT_BAD_CLOSE;
                out_next.where   = WHERE_W'(fail_where_after);
            end
            else if (count_after != '0)
            begin
                out_next.verdict = VERDICT_UNCLOSED;
                out_next.where   = WHERE_W'(where_after);
            end
            else
            begin
                out_next.verdict = VERDICT_OK;
            end
        end
    end

    always_comb
    begin
        char_index_next = char_index_reg;
        failed_next     = failed_reg;
        fail_where_next = fail_where_reg;
        overflowed_next = overflowed_reg;
        if (process)
        begin
            if (in_reg.last)
            begin
                char_index_next = '0;
                failed_next     = 1'b0;
                fail_where_next = '0;
                overflowed_next = 1'b0;
            end
            else
            begin
                char_index_next = pos;
                failed_next     = fail_after;
                fail_where_next = fail_where_after;
                overflowed_next = ovf_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
        end
        if (process)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            char_index_reg <= '0;
            failed_reg     <= 1'b0;
            fail_where_reg <= '0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            char_index_reg <= char_index_next;
            failed_reg     <= failed_next;
            fail_where_reg <= fail_where_next;
            overflowed_reg <= overflowed_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `BBC_ASSERT_SAME(a_fail_ovf_excl, 1'b1, !(failed_reg && overflowed_reg))
    `BBC_ASSERT_SAME(a_count_bound, 1'b1, stk_count <= CNT_W'(STACK_DEPTH))
    `BBC_ASSERT_NEXT(a_clear_after_last, process && in_reg.last, (char_index_reg == '0) && !failed_reg && !overflowed_reg && (stk_count == '0))
    `BBC_ASSERT_SAME(a_where_verdict, result_valid && (result.where != '0), (result.verdict == VERDICT_BAD_CLOSE) || (result.verdict == VERDICT_UNCLOSED))

endmodule
